### hdl/cse_pkg.sv
// Package: shared types, register codes and bit helpers of the CAN signal extractor.
`default_nettype none
package cse_pkg;

  localparam int unsigned DATA_W   = 64;
  localparam int unsigned DLC_W    = 4;
  localparam int unsigned CIDX_W   = 3;
  localparam int unsigned CDATA_W  = 64;
  localparam int unsigned SB_W     = 6;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned FACT_W   = 32;
  localparam int unsigned OFFS_W   = 48;
  localparam int unsigned PLO_W    = 65;
  localparam int unsigned PHI_W    = 64;
  localparam int unsigned SUM_W    = 96;

  typedef enum logic [CIDX_W-1:0] {
    CFG_SIG_START    = 3'd0,
    CFG_BIT_LENGTH   = 3'd1,
    CFG_BIG_ENDIAN   = 3'd2,
    CFG_SIGNED_VALUE = 3'd3,
    CFG_SCALE_FACTOR = 3'd4,
    CFG_SCALE_OFFSET = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [SB_W-1:0]          sig_start;
    logic [LEN_W-1:0]         bit_length;
    logic                     big_endian;
    logic                     signed_value;
    logic signed [FACT_W-1:0] scale_factor;
    logic signed [OFFS_W-1:0] scale_offset;
  } cfg_t;

  // Extracted item between the extract and scale units.
  typedef struct packed {
    logic              fits;
    logic [DATA_W-1:0] raw_value;
    logic [DATA_W-1:0] int_value;
  } ext_t;

  typedef struct packed {
    logic                     fits;
    logic [DATA_W-1:0]        raw_value;
    logic signed [DATA_W-1:0] int_value;
    logic signed [DATA_W-1:0] physical_value;
    logic                     saturated;
  } res_t;

  function automatic logic [DATA_W-1:0] byte_swap(input logic [DATA_W-1:0] d);
    logic [DATA_W-1:0] r;
    r = '0;
    for (int k = 0; k < DATA_W / 8; k++) begin
      r[8*k +: 8] = d[DATA_W - 8 - 8*k +: 8];
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] low_mask(input logic [LEN_W-1:0] n);
    logic [DATA_W-1:0] m;
    if (n >= LEN_W'(DATA_W)) begin
      m = '1;
    end else begin
      m = (DATA_W'(1) << n[SB_W-1:0]) - DATA_W'(1);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

### hdl/cse_in_if.sv
// Interface: input frame channel (payload bytes and DLC).
`default_nettype none
interface cse_in_if;
  logic                        valid;
  logic                        ready;
  logic [cse_pkg::DATA_W-1:0]  frame_data;
  logic [cse_pkg::DLC_W-1:0]   dlc;

  modport source (output valid, output frame_data, output dlc, input ready);
  modport sink (input valid, input frame_data, input dlc, output ready);
endinterface
`default_nettype wire

### hdl/cse_out_if.sv
// Interface: result channel (extracted and scaled signal).
`default_nettype none
interface cse_out_if;
  logic                              valid;
  logic                              ready;
  logic                              fits;
  logic [cse_pkg::DATA_W-1:0]        raw_value;
  logic signed [cse_pkg::DATA_W-1:0] int_value;
  logic signed [cse_pkg::DATA_W-1:0] physical_value;
  logic                              saturated;

  modport source (output valid, output fits, output raw_value, output int_value,
                  output physical_value, output saturated, input ready);
  modport sink (input valid, input fits, input raw_value, input int_value,
                input physical_value, input saturated, output ready);
endinterface
`default_nettype wire

### hdl/cse_cfg_if.sv
// Interface: configuration write channel (register index and data).
`default_nettype none
interface cse_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cse_pkg::CIDX_W-1:0]  index;
  logic [cse_pkg::CDATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hdl/can_signal_extract_scale.sv
// Top level: CAN DBC signal extraction and fixed-point scaling pipeline.
// One frame can be accepted on every clock unless a stalled result holds the
// pipeline. Its result passes through four register stages: range check and
// shift, mask and sign extension, split 64x32 multiply, offset add with
// saturation into the output register. The whole pipeline advances when the
// output register is empty or being taken, so a stalled result holds every
// stage in place.
// Configuration writes are accepted at any time and take effect on the next
// frame; write them only while no frame is in flight.
`default_nettype none
module can_signal_extract_scale (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cse_cfg_if.sink   cfg_i,
  cse_in_if.sink    frame_i,
  cse_out_if.source result_o
);
  import cse_pkg::*;

  cfg_t cfg;
  logic adv;
  logic ext_valid;
  ext_t ext;
  logic res_valid;
  res_t res;

  assign adv           = !res_valid | result_o.ready;
  assign frame_i.ready = adv;

  cse_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  cse_extract u_extract (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .cfg_i        (cfg),
    .valid_i      (frame_i.valid),
    .frame_data_i (frame_i.frame_data),
    .dlc_i        (frame_i.dlc),
    .valid_o      (ext_valid),
    .ext_o        (ext)
  );

  cse_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .cfg_i   (cfg),
    .valid_i (ext_valid),
    .ext_i   (ext),
    .valid_o (res_valid),
    .res_o   (res)
  );

  assign result_o.valid          = res_valid;
  assign result_o.fits           = res.fits;
  assign result_o.raw_value      = res.raw_value;
  assign result_o.int_value      = res.int_value;
  assign result_o.physical_value = res.physical_value;
  assign result_o.saturated      = res.saturated;

`ifndef SYNTHESIS
  a_nofit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res.fits) |->
      (res.raw_value == '0 && res.int_value == '0 &&
       res.physical_value == '0 && !res.saturated))
    else $error("non-fitting result carries nonzero values");

  a_sat_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.saturated) |->
      (res.physical_value == {1'b1, {(DATA_W-1){1'b0}}} ||
       res.physical_value == {1'b0, {(DATA_W-1){1'b1}}}))
    else $error("saturated result is not at a range limit");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !result_o.ready) |-> !frame_i.ready)
    else $error("frame taken while result stalled");

  a_unsigned_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !cfg.signed_value) |-> (res.int_value == res.raw_value))
    else $error("unsigned int_value differs from raw_value");
`endif

endmodule
`default_nettype wire

### hdl/cse_cfg_regs.sv
// Configuration register file of the signal extractor.
`default_nettype none
module cse_cfg_regs (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  cse_cfg_if.sink        cfg_i,
  output cse_pkg::cfg_t  cfg_o
);
  import cse_pkg::*;

  cfg_t cfg_q;
  logic wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid & cfg_i.ready;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sig_start    <= '0;
      cfg_q.bit_length   <= LEN_W'(8);
      cfg_q.big_endian   <= 1'b0;
      cfg_q.signed_value <= 1'b0;
      cfg_q.scale_factor <= FACT_W'(65536);
      cfg_q.scale_offset <= '0;
    end else if (wr) begin
      case (cfg_i.index)
        CFG_SIG_START:    cfg_q.sig_start    <= cfg_i.data[SB_W-1:0];
        CFG_BIT_LENGTH:   cfg_q.bit_length   <= cfg_i.data[LEN_W-1:0];
        CFG_BIG_ENDIAN:   cfg_q.big_endian   <= cfg_i.data[0];
        CFG_SIGNED_VALUE: cfg_q.signed_value <= cfg_i.data[0];
        CFG_SCALE_FACTOR: cfg_q.scale_factor <= cfg_i.data[FACT_W-1:0];
        CFG_SCALE_OFFSET: cfg_q.scale_offset <= cfg_i.data[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/cse_extract.sv
// Extract unit: range check and field shift (stage 1), mask and sign extension (stage 2).
`default_nettype none
module cse_extract (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     adv_i,
  input  wire cse_pkg::cfg_t            cfg_i,
  input  wire logic                     valid_i,
  input  wire logic [cse_pkg::DATA_W-1:0] frame_data_i,
  input  wire logic [cse_pkg::DLC_W-1:0]  dlc_i,
  output logic                          valid_o,
  output cse_pkg::ext_t                 ext_o
);
  import cse_pkg::*;

  logic [DLC_W-1:0]  dlc_eff;
  logic [7:0]        total;
  logic [SB_W-1:0]   first;
  logic [7:0]        span;
  logic              ok;
  logic [DATA_W-1:0] src;
  logic [7:0]        shamt;

  logic              v1_q;
  logic              fits1_q, fits1_d;
  logic [DATA_W-1:0] shf1_q, shf1_d;

  logic              v2_q;
  ext_t              ext2_q, ext2_d;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] raw;
  logic [LEN_W-1:0]  msb_idx;

  // Stage 1: classic CAN caps the DLC at eight bytes.
  always_comb begin
    dlc_eff = (dlc_i > DLC_W'(8)) ? DLC_W'(8) : dlc_i;
    total   = {1'b0, dlc_eff, 3'b000};
    // Motorola start bit names the MSB; flip the bit within its byte.
    first   = cfg_i.big_endian ? {cfg_i.sig_start[5:3], ~cfg_i.sig_start[2:0]}
                               : cfg_i.sig_start;
    span    = 8'(first) + 8'(cfg_i.bit_length);
    ok      = (cfg_i.bit_length != '0) && (cfg_i.bit_length <= LEN_W'(DATA_W)) &&
              (span <= total);
    // In Motorola order the byte-swapped word holds the field MSB-first, LSB at 64-span.
    src     = cfg_i.big_endian ? byte_swap(frame_data_i) : frame_data_i;
    shamt   = cfg_i.big_endian ? (8'(DATA_W) - span) : 8'(cfg_i.sig_start);
    shf1_d  = src >> shamt[SB_W-1:0];
    fits1_d = ok;
  end

  // Stage 2: mask to length, sign-extend when asked.
  always_comb begin
    mask    = low_mask(cfg_i.bit_length);
    raw     = fits1_q ? (shf1_q & mask) : '0;
    msb_idx = cfg_i.bit_length - LEN_W'(1);
    ext2_d.fits      = fits1_q;
    ext2_d.raw_value = raw;
    if (cfg_i.signed_value && (cfg_i.bit_length < LEN_W'(DATA_W)) &&
        raw[msb_idx[SB_W-1:0]]) begin
      ext2_d.int_value = raw | ~mask;
    end else begin
      ext2_d.int_value = raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fits1_q <= fits1_d;
      shf1_q  <= shf1_d;
      ext2_q  <= ext2_d;
    end
  end

  assign valid_o = v2_q;
  assign ext_o   = ext2_q;

endmodule
`default_nettype wire

### hdl/cse_scale.sv
// Scale unit: split multiply (stage 3), offset add and saturation into the output register.
`default_nettype none
module cse_scale (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire cse_pkg::cfg_t cfg_i,
  input  wire logic          valid_i,
  input  wire cse_pkg::ext_t ext_i,
  output logic               valid_o,
  output cse_pkg::res_t      res_o
);
  import cse_pkg::*;

  logic signed [32:0]      a_lo;
  logic signed [31:0]      a_hi;
  logic signed [PLO_W-1:0] plo_q, plo_d;
  logic signed [PHI_W-1:0] phi_q, phi_d;
  logic                    v3_q;
  ext_t                    ext3_q;

  logic signed [SUM_W-1:0] sum;
  logic                    in_range;
  res_t                    res_q, res_d;
  logic                    vo_q;

  // Stage 3: int_value = hi*2^32 + lo, lo unsigned; two 32x32 products.
  always_comb begin
    a_lo  = $signed({1'b0, ext_i.int_value[31:0]});
    a_hi  = $signed(ext_i.int_value[63:32]);
    plo_d = PLO_W'(a_lo) * PLO_W'(cfg_i.scale_factor);
    phi_d = PHI_W'(a_hi) * PHI_W'(cfg_i.scale_factor);
  end

  // Stage 4: exact sum in 96 bits, then clip to 64.
  always_comb begin
    sum      = $signed({phi_q, 32'd0}) + SUM_W'(plo_q) + SUM_W'(cfg_i.scale_offset);
    in_range = (sum[SUM_W-1:DATA_W-1] == '0) || (sum[SUM_W-1:DATA_W-1] == '1);
    res_d.fits      = ext3_q.fits;
    res_d.raw_value = ext3_q.raw_value;
    res_d.int_value = ext3_q.int_value;
    if (!ext3_q.fits) begin
      res_d.physical_value = '0;
      res_d.saturated      = 1'b0;
    end else if (in_range) begin
      res_d.physical_value = sum[DATA_W-1:0];
      res_d.saturated      = 1'b0;
    end else begin
      res_d.physical_value = sum[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                          : {1'b0, {(DATA_W-1){1'b1}}};
      res_d.saturated      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= valid_i;
      vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      plo_q  <= plo_d;
      phi_q  <= phi_d;
      ext3_q <= ext_i;
      res_q  <= res_d;
    end
  end

  assign valid_o = vo_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

### test/can_signal_scoreboard_pkg.sv
// Scoreboard for the CAN signal extractor: register shadow, result predictor and checker.
package can_signal_scoreboard_pkg;
  import cse_pkg::*;

  class signal_scoreboard;
    cfg_t        regs;
    res_t        expected_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      regs.sig_start    = '0;
      regs.bit_length   = LEN_W'(8);
      regs.big_endian   = 1'b0;
      regs.signed_value = 1'b0;
      regs.scale_factor = FACT_W'(65536);
      regs.scale_offset = '0;
    endfunction

    function void write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] value);
      case (idx)
        CFG_SIG_START:    regs.sig_start    = value[SB_W-1:0];
        CFG_BIT_LENGTH:   regs.bit_length   = value[LEN_W-1:0];
        CFG_BIG_ENDIAN:   regs.big_endian   = value[0];
        CFG_SIGNED_VALUE: regs.signed_value = value[0];
        CFG_SCALE_FACTOR: regs.scale_factor = value[FACT_W-1:0];
        CFG_SCALE_OFFSET: regs.scale_offset = value[OFFS_W-1:0];
        default: ;
      endcase
    endfunction

    function res_t extract_and_scale(input logic [DATA_W-1:0] data, input logic [DLC_W-1:0] dlc);
      res_t               r;
      int unsigned        len, sbit, first, bytes, pos, src;
      logic [DATA_W-1:0]  mask, raw, ival;
      logic signed [127:0] wide_int, wide_fact, wide_offs, acc;
      r     = '0;
      len   = regs.bit_length;
      sbit  = regs.sig_start;
      bytes = (dlc > DLC_W'(8)) ? 8 : dlc;
      // Motorola numbering counts from the msb of the start byte
      first = regs.big_endian ? (sbit / 8) * 8 + 7 - sbit % 8 : sbit;
      if (len == 0 || len > 64 || first + len > bytes * 8) begin
        return r;
      end
      mask = ~({DATA_W{1'b1}} << len);
      if (regs.big_endian) begin
        raw = '0;
        for (int i = 0; i < len; i++) begin
          pos = first + i;
          src = (pos / 8) * 8 + 7 - pos % 8;
          raw = {raw[DATA_W-2:0], data[src]};
        end
      end else begin
        raw = (data >> sbit) & mask;
      end
      ival = raw;
      if (regs.signed_value && len < 64 && raw[len-1]) begin
        ival = raw | ~mask;
      end
      wide_int  = $signed(ival);
      wide_fact = $signed(regs.scale_factor);
      wide_offs = $signed(regs.scale_offset);
      acc = wide_int * wide_fact + wide_offs;
      r.fits      = 1'b1;
      r.raw_value = raw;
      r.int_value = ival;
      // clip when the upper bits are not a sign extension of bit 63
      if (acc[127:63] != {65{acc[127]}}) begin
        r.saturated      = 1'b1;
        r.physical_value = acc[127] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
      end else begin
        r.physical_value = acc[63:0];
      end
      return r;
    endfunction

    function void note_frame(input logic [DATA_W-1:0] data, input logic [DLC_W-1:0] dlc);
      expected_q.push_back(extract_and_scale(data, dlc));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report(input string what, input logic [63:0] got_v, input logic [63:0] exp_v);
      if (mismatches < 100) begin
        $display("%0t ns mismatch %s: got %h expected %h", $time, what, got_v, exp_v);
      end
      mismatches++;
    endtask

    task check_result(input res_t got);
      res_t exp;
      if (expected_q.size() == 0) begin
        report("result with no frame pending", got.raw_value, '0);
        return;
      end
      exp = expected_q.pop_front();
      if (got.fits !== exp.fits) report("fits", 64'(got.fits), 64'(exp.fits));
      if (got.raw_value !== exp.raw_value) report("raw_value", got.raw_value, exp.raw_value);
      if (got.int_value !== exp.int_value) report("int_value", got.int_value, exp.int_value);
      if (got.physical_value !== exp.physical_value) begin
        report("physical_value", got.physical_value, exp.physical_value);
      end
      if (got.saturated !== exp.saturated) begin
        report("saturated", 64'(got.saturated), 64'(exp.saturated));
      end
    endtask
  endclass

endpackage

### test/tb_top.sv
// Testbench top: drives frames and register writes into the CAN signal extractor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cse_pkg::*;
  import can_signal_scoreboard_pkg::*;

  localparam int unsigned TOTAL_ITEMS  = 650;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned LIMIT_CYCLES = 500000;
  localparam logic [CIDX_W-1:0] CFG_SPARE = CIDX_W'(CFG_SCALE_OFFSET) + CIDX_W'(1);

  logic clk_i = 1'b0;
  logic rst_ni;

  cse_cfg_if cfg_bus ();
  cse_in_if  frame_bus ();
  cse_out_if result_bus ();

  can_signal_extract_scale dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .frame_i  (frame_bus),
    .result_o (result_bus)
  );

  signal_scoreboard sb;
  int unsigned      items_sent = 0;
  int unsigned      cycles = 0;
  int unsigned      phase_need = 8;
  bit               frame_gaps_on = 1'b0;
  bit               result_stalls_on = 1'b0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 6);
    return $urandom_range(12, 40);
  endfunction

  // Result sink: hold ready low for random stretches.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    result_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        if (result_stalls_on && $urandom_range(0, 99) < 25) stall_left = pause_len();
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    res_t got;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      got.fits           = result_bus.fits;
      got.raw_value      = result_bus.raw_value;
      got.int_value      = result_bus.int_value;
      got.physical_value = result_bus.physical_value;
      got.saturated      = result_bus.saturated;
      sb.check_result(got);
    end
  end

  // All driving tasks start and end just after a falling edge.
  task automatic send_frame(input logic [DATA_W-1:0] data, input logic [DLC_W-1:0] dlc);
    int unsigned gap;
    gap = 0;
    if (frame_gaps_on && $urandom_range(0, 99) >= 55) gap = pause_len();
    if (gap != 0) begin
      frame_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    frame_bus.valid      <= 1'b1;
    frame_bus.frame_data <= data;
    frame_bus.dlc        <= dlc;
    do @(posedge clk_i); while (!frame_bus.ready);
    sb.note_frame(data, dlc);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    sb.write_reg(idx, value);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every result is back and the pipeline is empty.
  task automatic settle();
    frame_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [CDATA_W-1:0] with_junk(input logic [CDATA_W-1:0] v,
                                                   input int unsigned w, input bit junk);
    if (!junk) return v;
    return v | ({$urandom, $urandom} << w);
  endfunction

  task automatic apply_setting(input logic [SB_W-1:0] start, input logic [LEN_W-1:0] len,
                               input bit be, input bit sgn, input logic [FACT_W-1:0] factor,
                               input logic [OFFS_W-1:0] offset, input bit junk);
    settle();
    write_reg(CFG_SIG_START, with_junk(CDATA_W'(start), SB_W, junk));
    write_reg(CFG_BIT_LENGTH, with_junk(CDATA_W'(len), LEN_W, junk));
    write_reg(CFG_BIG_ENDIAN, with_junk(CDATA_W'(be), 1, junk));
    write_reg(CFG_SIGNED_VALUE, with_junk(CDATA_W'(sgn), 1, junk));
    write_reg(CFG_SCALE_FACTOR, with_junk(CDATA_W'(factor), FACT_W, junk));
    write_reg(CFG_SCALE_OFFSET, with_junk(CDATA_W'(offset), OFFS_W, junk));
    // unused indexes must leave every register alone
    if (junk) begin
      write_reg(CIDX_W'($urandom_range(int'(CFG_SPARE), (1 << CIDX_W) - 1)),
                {$urandom, $urandom});
    end
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic random_setting();
    int unsigned r, len, msb, first;
    logic [SB_W-1:0]   start;
    logic [FACT_W-1:0] factor;
    logic [OFFS_W-1:0] offset;
    bit be;
    r  = $urandom_range(0, 99);
    be = 1'($urandom_range(0, 1));
    if (r < 4) len = 0;
    else if (r < 9) len = $urandom_range(65, 127);
    else if (r < 22) len = 64;
    else if (r < 48) len = $urandom_range(1, 8);
    else len = $urandom_range(1, 63);
    if (len >= 1 && len <= 64 && $urandom_range(0, 99) < 85) begin
      // place the field inside the payload
      msb   = $urandom_range(0, 64 - len);
      start = be ? {msb[5:3], ~msb[2:0]} : SB_W'(msb);
    end else begin
      start = SB_W'($urandom_range(0, 63));
    end
    first = be ? {start[5:3], ~start[2:0]} : start;
    phase_need = (first + len + 7) / 8;
    r = $urandom_range(0, 99);
    if (r < 20) factor = FACT_W'(65536);
    else if (r < 35) factor = FACT_W'($urandom_range(0, 2000)) - FACT_W'(1000);
    else if (r < 43) factor = {1'b0, {(FACT_W-1){1'b1}}};
    else if (r < 51) factor = {1'b1, {(FACT_W-1){1'b0}}};
    else factor = $urandom;
    r = $urandom_range(0, 99);
    if (r < 30) offset = '0;
    else if (r < 38) offset = {1'b0, {(OFFS_W-1){1'b1}}};
    else if (r < 46) offset = {1'b1, {(OFFS_W-1){1'b0}}};
    else if (r < 70) offset = OFFS_W'($urandom_range(0, 200000)) - OFFS_W'(100000);
    else offset = OFFS_W'({$urandom, $urandom});
    apply_setting(start, LEN_W'(len), be, 1'($urandom_range(0, 1)), factor, offset,
                  $urandom_range(0, 99) < 30);
  endtask

  function automatic logic [DLC_W-1:0] rand_dlc();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (phase_need <= 8 && r < 65) return DLC_W'($urandom_range(phase_need, 8));
    if (r < 80) return DLC_W'($urandom_range(9, 15));
    return DLC_W'($urandom_range(0, 15));
  endfunction

  function automatic logic [DATA_W-1:0] rand_data();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 12) return '1;
    if (r < 20) return DATA_W'(1) << $urandom_range(0, 63);
    return {$urandom, $urandom};
  endfunction

  initial begin
    int unsigned n;
    sb = new();
    rst_ni = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    frame_bus.valid = 1'b0;
    frame_bus.frame_data = '0;
    frame_bus.dlc = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset setting: one unsigned Intel byte at bit 0; empty frame, oversized DLC.
    send_frame('0, DLC_W'(0));
    send_frame('1, DLC_W'(1));
    send_frame('1, DLC_W'(15));
    send_frame(64'h0123_4567_89ab_cdef, DLC_W'(8));

    // Full-length signed field, largest factor and offset: both overflow directions.
    apply_setting('0, LEN_W'(64), 1'b0, 1'b1, {1'b0, {(FACT_W-1){1'b1}}},
                  {1'b0, {(OFFS_W-1){1'b1}}}, 1'b0);
    send_frame('1, DLC_W'(8));
    send_frame({1'b0, {63{1'b1}}}, DLC_W'(8));
    send_frame({1'b1, {63{1'b0}}}, DLC_W'(8));
    send_frame('1, DLC_W'(7));

    // Motorola byte at the top start bit.
    apply_setting(SB_W'(63), LEN_W'(8), 1'b1, 1'b1, FACT_W'(-65536), '0, 1'b0);
    send_frame({8'h80, 56'h0}, DLC_W'(8));
    send_frame(64'h0123_4567_89ab_cdef, DLC_W'(8));
    send_frame('1, DLC_W'(7));

    // Motorola full length.
    apply_setting(SB_W'(7), LEN_W'(64), 1'b1, 1'b0, FACT_W'(65536), '0, 1'b0);
    send_frame(64'h0123_4567_89ab_cdef, DLC_W'(8));
    send_frame(64'hfedc_ba98_7654_3210, DLC_W'(12));

    // Invalid lengths.
    apply_setting('0, '0, 1'b0, 1'b0, FACT_W'(65536), '0, 1'b0);
    send_frame('1, DLC_W'(8));
    apply_setting('0, LEN_W'(65), 1'b0, 1'b0, FACT_W'(65536), '0, 1'b0);
    send_frame('1, DLC_W'(8));
    apply_setting('0, '1, 1'b1, 1'b1, FACT_W'(65536), '0, 1'b1);
    send_frame('1, DLC_W'(8));

    // Smallest factor and offset.
    apply_setting('0, LEN_W'(64), 1'b0, 1'b1, {1'b1, {(FACT_W-1){1'b0}}},
                  {1'b1, {(OFFS_W-1){1'b0}}}, 1'b0);
    send_frame({1'b0, {63{1'b1}}}, DLC_W'(8));
    send_frame({1'b1, {63{1'b0}}}, DLC_W'(8));
    send_frame('0, DLC_W'(8));

    // Intel nibble at the top of the payload.
    apply_setting(SB_W'(60), LEN_W'(4), 1'b0, 1'b1, FACT_W'(98304), OFFS_W'(-1), 1'b0);
    send_frame('1, DLC_W'(8));
    send_frame('1, DLC_W'(7));

    while (items_sent < TOTAL_ITEMS) begin
      random_setting();
      frame_gaps_on    = $urandom_range(0, 3) != 0;
      result_stalls_on = $urandom_range(0, 3) != 0;
      n = $urandom_range(20, 60);
      repeat (n) send_frame(rand_data(), rand_dlc());
    end
    settle();

    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
